// File: sv/rbf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rbf_pkg: shared types and constants for the banked register file
// Opcodes, mode, bank and error codes, condition codes, types and decode helpers.
// ============================================================================
package rbf_pkg;

   // opcodes
   localparam logic [2:0] OP_READ_REG   = 3'd0;
   localparam logic [2:0] OP_WRITE_REG  = 3'd1;
   localparam logic [2:0] OP_WRITE_STAT = 3'd2;
   localparam logic [2:0] OP_SET_MODE   = 3'd3;
   localparam logic [2:0] OP_CHECK_COND = 3'd4;
   localparam logic [2:0] OP_READ_SAVED = 3'd5;
   localparam logic [2:0] OP_WRITE_SAVED = 3'd6;

   // mode encodings
   localparam logic [4:0] MODE_USR = 5'h10;
   localparam logic [4:0] MODE_FIQ = 5'h11;
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_UND = 5'h1B;
   localparam logic [4:0] MODE_SYS = 5'h1F;

   // bank codes
   localparam logic [2:0] BANK_USR  = 3'd0;
   localparam logic [2:0] BANK_FIQ  = 3'd1;
   localparam logic [2:0] BANK_IRQ  = 3'd2;
   localparam logic [2:0] BANK_SVC  = 3'd3;
   localparam logic [2:0] BANK_ABT  = 3'd4;
   localparam logic [2:0] BANK_UND  = 3'd5;
   localparam logic [2:0] BANK_NONE = 3'd6;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_MODE = 2'd1;
   localparam logic [1:0] ERR_NO_SAVED = 2'd2;

   // condition codes
   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_CS = 4'd2;
   localparam logic [3:0] COND_CC = 4'd3;
   localparam logic [3:0] COND_MI = 4'd4;
   localparam logic [3:0] COND_PL = 4'd5;
   localparam logic [3:0] COND_VS = 4'd6;
   localparam logic [3:0] COND_VC = 4'd7;
   localparam logic [3:0] COND_HI = 4'd8;
   localparam logic [3:0] COND_LS = 4'd9;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;

   localparam logic [31:0] STATUS_MASK = 32'hF800_00FF;
   localparam logic [31:0] STATUS_RESET = 32'h0000_0010;
   localparam int T_BIT = 5;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  reg_index;
      logic [31:0] data;
      logic [4:0]  mode;
      logic [3:0]  cond;
   } req_type;

   typedef struct packed {
      logic       cond_passed;
      logic       flush;
      logic [1:0] error;
   } flags_type;

   function automatic logic [2:0] bank_of_mode(input logic [4:0] m);
      logic [2:0] b;
      unique case (m)
         MODE_USR, MODE_SYS: b = BANK_USR;
         MODE_FIQ:           b = BANK_FIQ;
         MODE_IRQ:           b = BANK_IRQ;
         MODE_SVC:           b = BANK_SVC;
         MODE_ABT:           b = BANK_ABT;
         MODE_UND:           b = BANK_UND;
         default:            b = BANK_NONE;
      endcase
      return b;
   endfunction

   // banks that own a saved status
   function automatic logic has_saved(input logic [2:0] b);
      return (b >= BANK_FIQ) && (b <= BANK_UND);
   endfunction

   // flags: n z c v from status[31:28]
   function automatic logic cond_check(input logic [3:0] c, input logic [3:0] f);
      logic n, z, cf, v, r;
      n  = f[3];
      z  = f[2];
      cf = f[1];
      v  = f[0];
      unique case (c)
         COND_EQ: r = z;
         COND_NE: r = !z;
         COND_CS: r = cf;
         COND_CC: r = !cf;
         COND_MI: r = n;
         COND_PL: r = !n;
         COND_VS: r = v;
         COND_VC: r = !v;
         COND_HI: r = cf && !z;
         COND_LS: r = !cf || z;
         COND_GE: r = (n == v);
         COND_LT: r = (n != v);
         COND_GT: r = !z && (n == v);
         COND_LE: r = z || (n != v);
         default: r = 1'b1;
      endcase
      return r;
   endfunction

endpackage

// File: sv/rbf_bank.sv
`timescale 1ns / 1ps
// ============================================================================
// rbf_bank: general-purpose and saved status storage
// Common, FIQ and per-mode r13/r14 registers plus the saved status words,
// routed by the current bank.
// ============================================================================
module rbf_bank
   import rbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        exec,
   input  req_type     req,
   input  logic [2:0]  bank,
   output logic [31:0] reg_rdata,
   output logic [31:0] saved_rdata
);

   logic [31:0] common_ff [16];
   logic [31:0] fiq_ff    [7];
   logic [31:0] pair_ff   [8];
   logic [31:0] saved_ff  [5];

   logic       fiq_hit;
   logic       pair_hit;
   logic [2:0] fiq_idx;
   logic [2:0] pair_idx;
   logic [2:0] saved_idx;
   logic [2:0] bank_off;
   logic       reg_we;
   logic       saved_we;

   always_comb begin
      fiq_hit   = (bank == BANK_FIQ) && (req.reg_index >= 4'd8) && (req.reg_index <= 4'd14);
      pair_hit  = (bank >= BANK_IRQ) && (bank <= BANK_UND) && (req.reg_index >= 4'd13)
                  && (req.reg_index <= 4'd14);
      fiq_idx   = req.reg_index[2:0];                // idx - 8
      bank_off  = bank - BANK_IRQ;
      pair_idx  = {bank_off[1:0], ~req.reg_index[0]}; // r13 -> 0, r14 -> 1
      saved_idx = bank - BANK_FIQ;
      reg_we    = exec && (req.op == OP_WRITE_REG);
      saved_we  = exec && (req.op == OP_WRITE_SAVED) && has_saved(bank);
   end

   always_comb begin
      priority if (fiq_hit) begin
         reg_rdata = fiq_ff[fiq_idx];
      end else if (pair_hit) begin
         reg_rdata = pair_ff[pair_idx];
      end else begin
         reg_rdata = common_ff[req.reg_index];
      end
      saved_rdata = has_saved(bank) ? saved_ff[saved_idx] : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) common_ff[i] <= '0;
         for (int i = 0; i < 7; i++)  fiq_ff[i]    <= '0;
         for (int i = 0; i < 8; i++)  pair_ff[i]   <= '0;
         for (int i = 0; i < 5; i++)  saved_ff[i]  <= '0;
      end else begin
         if (reg_we) begin
            priority if (fiq_hit) begin
               fiq_ff[fiq_idx] <= req.data;
            end else if (pair_hit) begin
               pair_ff[pair_idx] <= req.data;
            end else begin
               common_ff[req.reg_index] <= req.data;
            end
         end
         if (saved_we) begin
            saved_ff[saved_idx] <= req.data;
         end
      end
   end

endmodule

// File: sv/rbf_status.sv
`timescale 1ns / 1ps
// ============================================================================
// rbf_status: status register and bank selection
// Status writes, mode changes, condition checks, flush and error flags.
// ============================================================================
module rbf_status
   import rbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        exec,
   input  req_type     req,
   output logic [31:0] status,
   output logic [31:0] status_next,
   output logic [2:0]  bank,
   output flags_type   flags
);

   logic [31:0] status_ff, status_in;
   logic [2:0]  bank_ff, bank_in;
   logic [4:0]  new_mode;
   logic [2:0]  new_bank;
   logic        mode_sw;

   always_comb begin
      status_in   = status_ff;
      bank_in     = bank_ff;
      flags       = '0;
      new_mode    = status_ff[4:0];
      mode_sw     = 1'b0;
      unique case (req.op)
         OP_WRITE_STAT: begin
            status_in  = req.data & STATUS_MASK;
            new_mode   = req.data[4:0];
            mode_sw    = (req.data[4:0] != status_ff[4:0]);
            flags.flush = (req.data[T_BIT] != status_ff[T_BIT]);
         end
         OP_SET_MODE: begin
            new_mode  = req.mode;
            mode_sw   = (req.mode != status_ff[4:0]);
            if (mode_sw) begin
               status_in = {status_ff[31:5], req.mode};
            end
         end
         OP_CHECK_COND: begin
            flags.cond_passed = cond_check(req.cond, status_ff[31:28]);
         end
         OP_READ_SAVED, OP_WRITE_SAVED: begin
            if (!has_saved(bank_ff)) begin
               flags.error = ERR_NO_SAVED;
            end
         end
         default: begin
         end
      endcase
      new_bank = bank_of_mode(new_mode);
      if (mode_sw) begin
         if (new_bank == BANK_NONE) begin
            flags.error = ERR_BAD_MODE;
         end else begin
            bank_in = new_bank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= STATUS_RESET;
         bank_ff   <= BANK_USR;
      end else if (exec) begin
         status_ff <= status_in;
         bank_ff   <= bank_in;
      end
   end

   assign status      = status_ff;
   assign status_next = status_in;
   assign bank        = bank_ff;

endmodule

// File: sv/banked_register_file_with_status.sv
`timescale 1ns / 1ps
// ============================================================================
// banked_register_file_with_status: banked r0-r15 with status register
// Top level: input register, execute logic, result register.
// ============================================================================
// One access per item: register read/write through the current mode's bank
// (FIQ banks r8-r14; IRQ, SVC, ABT, UND bank r13/r14), status write masked to
// 0xF80000FF, mode set, condition check against NZCV, saved status read or
// write. Every item yields exactly one result item. An accepted item sits in
// the input register until the output slot frees, is executed against the
// register file and status in a single combinational pass, and its result is
// loaded into the output register; the state update lands at the same edge,
// so the next item sees it. Throughput is one item per clock while rsp_tready
// stays high; a result reaches rsp_* through the input and output registers.
// A stalled result stops execution but the input register still holds one
// item behind it.
// ============================================================================
module banked_register_file_with_status
   import rbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: reg_index[3:0], data[35:4], mode[40:36], cond[44:41], zero pad
   input  logic [47:0] req_tdata,
   // tuser: op[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: read_data[31:0], cond_passed[32], flush[33], error[35:34], pad
   output logic [39:0] rsp_tdata
);

   logic        in_valid_ff, in_valid_in;
   req_type     req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff;

   logic        advance;
   logic        exec;
   logic        req_take;

   logic [31:0] reg_rdata;
   logic [31:0] saved_rdata;
   logic [31:0] status;
   logic [31:0] status_next;
   logic [2:0]  bank;
   flags_type   flags;
   logic [31:0] read_data;

   // output slot frees up when empty or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign exec       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (exec ? 1'b0 : in_valid_ff);
      rsp_valid_in = exec ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.op        <= req_tuser;
         req_ff.reg_index <= req_tdata[3:0];
         req_ff.data      <= req_tdata[35:4];
         req_ff.mode      <= req_tdata[40:36];
         req_ff.cond      <= req_tdata[44:41];
      end
      if (exec) begin
         rsp_data_ff <= {4'd0, flags.error, flags.flush, flags.cond_passed, read_data};
      end
   end

   rbf_bank u_bank (
      .clock       (clock),
      .reset       (reset),
      .exec        (exec),
      .req         (req_ff),
      .bank        (bank),
      .reg_rdata   (reg_rdata),
      .saved_rdata (saved_rdata)
   );

   rbf_status u_status (
      .clock       (clock),
      .reset       (reset),
      .exec        (exec),
      .req         (req_ff),
      .status      (status),
      .status_next (status_next),
      .bank        (bank),
      .flags       (flags)
   );

   // register value, saved status when present, else post-op status
   always_comb begin
      priority if (req_ff.op == OP_READ_REG) begin
         read_data = reg_rdata;
      end else if ((req_ff.op == OP_READ_SAVED) && has_saved(bank)) begin
         read_data = saved_rdata;
      end else begin
         read_data = status_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // executed item always lands in the result register
   a_exec_to_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_tvalid)
      else $error("executed item did not reach result register");

   // bank code stays within the six real banks
   a_bank_range: assert property (@(posedge clock) disable iff (reset)
      bank <= BANK_UND)
      else $error("bank select out of range");

   // with a valid mode in status, the selected bank matches it
   a_bank_tracks_mode: assert property (@(posedge clock) disable iff (reset)
      (bank_of_mode(status[4:0]) != BANK_NONE) |-> (bank_of_mode(status[4:0]) == bank))
      else $error("bank select disagrees with status mode");
`endif

endmodule

// File: dv/tb_banked_register_file_with_status.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_banked_register_file_with_status: self-checking bench for the register file
// Drives register, status, mode, condition and saved-status accesses over the
// request stream. A cycle-free predictor holds its own image of every bank and
// the status word. Each response item is checked field by field, in order.
// ============================================================================
module tb_banked_register_file_with_status;
   import rbf_pkg::*;

   // opcode 7 has no package name; the block must treat it as a no-op
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // response fields, packed to match rsp_tdata[35:0]
   typedef struct packed {
      logic [1:0]  error;
      logic        flush;
      logic        cond_passed;
      logic [31:0] read_data;
   } rsp_fields_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // tdata: reg_index[3:0], data[35:4], mode[40:36], cond[44:41], zero pad
   logic [47:0] req_tdata = '0;
   // tuser: op[2:0]
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // tdata: read_data[31:0], cond_passed[32], flush[33], error[35:34], pad
   logic [39:0] rsp_tdata;

   banked_register_file_with_status i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor state. One flat image of all physical registers:
   //   0..15  common r0-r15, 16..22 FIQ r8-r14,
   //   23..30 r13/r14 pairs for IRQ, SVC, ABT, UND in that order.
   // ---------------------------------------------------------------------------
   logic [31:0] gpr_image [31];
   logic [31:0] spsr_image [5];      // FIQ, IRQ, SVC, ABT, UND
   logic [31:0] psr_image;
   logic [2:0]  bank_image;

   rsp_fields_type access_results_q [$];

   int error_count;
   int items_sent;
   int results_checked;
   int op_count [8];

   int req_idle_pct;                 // sender gap chance, percent
   int rsp_idle_pct;                 // receiver stall chance, percent
   int rsp_hold_cycles;              // long receiver hold-off request

   logic [4:0] legal_modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                   MODE_ABT, MODE_UND, MODE_SYS};

   function automatic logic [2:0] bank_for_mode(input logic [4:0] m);
      case (m)
         MODE_USR, MODE_SYS: return BANK_USR;
         MODE_FIQ:           return BANK_FIQ;
         MODE_IRQ:           return BANK_IRQ;
         MODE_SVC:           return BANK_SVC;
         MODE_ABT:           return BANK_ABT;
         MODE_UND:           return BANK_UND;
         default:            return BANK_NONE;
      endcase
   endfunction

   // new mode already in psr_image; an unknown mode keeps the old bank
   function automatic logic [1:0] switch_bank();
      logic [2:0] nb;
      nb = bank_for_mode(psr_image[4:0]);
      if (nb == BANK_NONE)
         return ERR_BAD_MODE;
      bank_image = nb;
      return ERR_NONE;
   endfunction

   // physical slot for r<idx> as seen from the current bank
   function automatic logic [4:0] reg_location(input logic [3:0] idx,
                                               input logic [2:0] bank);
      if (bank == BANK_FIQ && idx >= 8 && idx <= 14)
         return 5'(16 + idx - 8);
      if (bank >= BANK_IRQ && bank <= BANK_UND && idx >= 13 && idx <= 14)
         return 5'(23 + (bank - BANK_IRQ) * 2 + (idx - 13));
      return {1'b0, idx};
   endfunction

   function automatic logic cond_holds(input logic [3:0] c, input logic [31:0] psr);
      logic n, z, cy, v;
      n  = psr[31];
      z  = psr[30];
      cy = psr[29];
      v  = psr[28];
      case (c)
         COND_EQ: return z;
         COND_NE: return !z;
         COND_CS: return cy;
         COND_CC: return !cy;
         COND_MI: return n;
         COND_PL: return !n;
         COND_VS: return v;
         COND_VC: return !v;
         COND_HI: return cy && !z;
         COND_LS: return !cy || z;
         COND_GE: return n == v;
         COND_LT: return n != v;
         COND_GT: return !z && (n == v);
         COND_LE: return z || (n != v);
         default: return 1'b1;      // AL and the special code both pass
      endcase
   endfunction

   // Applies one accepted access to the images and queues its response.
   task automatic execute_access(input req_type a);
      rsp_fields_type r;
      logic           read_done;
      logic           mode_moved;
      r = '0;
      read_done = 1'b0;
      op_count[a.op]++;
      case (a.op)
         OP_READ_REG: begin
            r.read_data = gpr_image[reg_location(a.reg_index, bank_image)];
            read_done = 1'b1;
         end
         OP_WRITE_REG: begin
            gpr_image[reg_location(a.reg_index, bank_image)] = a.data;
         end
         OP_WRITE_STAT: begin
            r.flush = a.data[T_BIT] != psr_image[T_BIT];
            mode_moved = a.data[4:0] != psr_image[4:0];
            psr_image = a.data & STATUS_MASK;
            if (mode_moved)
               r.error = switch_bank();
         end
         OP_SET_MODE: begin
            // rewriting the same mode is silent, even an illegal one
            if (psr_image[4:0] != a.mode) begin
               psr_image[4:0] = a.mode;
               r.error = switch_bank();
            end
         end
         OP_CHECK_COND: begin
            r.cond_passed = cond_holds(a.cond, psr_image);
         end
         OP_READ_SAVED: begin
            if (bank_image >= BANK_FIQ && bank_image <= BANK_UND) begin
               r.read_data = spsr_image[bank_image - BANK_FIQ];
               read_done = 1'b1;
            end else begin
               r.error = ERR_NO_SAVED;
            end
         end
         OP_WRITE_SAVED: begin
            if (bank_image >= BANK_FIQ && bank_image <= BANK_UND)
               spsr_image[bank_image - BANK_FIQ] = a.data;
            else
               r.error = ERR_NO_SAVED;
         end
         default: begin
         end
      endcase
      if (!read_done)
         r.read_data = psr_image;
      access_results_q.push_back(r);
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus. Called at a rising edge; returns at the edge where the item went
   // in, so the next call can keep tvalid high without a dip.
   // ---------------------------------------------------------------------------
   task automatic send_access(input req_type a);
      // each cycle idles with the given chance before the item is offered
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= a.op;
      req_tdata  <= {3'b000, a.cond, a.mode, a.data, a.reg_index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      execute_access(a);
      items_sent++;
   endtask

   function automatic req_type make_access(input logic [2:0] op, input logic [3:0] idx,
                                           input logic [31:0] data, input logic [4:0] mode,
                                           input logic [3:0] cond);
      req_type a;
      a.op        = op;
      a.reg_index = idx;
      a.data      = data;
      a.mode      = mode;
      a.cond      = cond;
      return a;
   endfunction

   // Mostly legal mode traffic so the banked registers and saved status get
   // real use; the rest is illegal modes and saved-status access in user mode.
   function automatic req_type random_access();
      req_type a;
      int      pick;
      a.reg_index = 4'($urandom_range(15));
      if ($urandom_range(1))
         a.reg_index = 4'($urandom_range(8, 15));   // favor the banked range
      a.data = $urandom;
      if ($urandom_range(9) == 0)
         a.data = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      a.mode = 5'($urandom_range(31));
      a.cond = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 25) begin
         a.op = OP_READ_REG;
      end else if (pick < 50) begin
         a.op = OP_WRITE_REG;
      end else if (pick < 60) begin
         a.op = OP_WRITE_STAT;
         if ($urandom_range(9) != 0)
            a.data[4:0] = legal_modes[3'($urandom_range(6))];
      end else if (pick < 73) begin
         a.op = OP_SET_MODE;
         if ($urandom_range(9) != 0)
            a.mode = legal_modes[3'($urandom_range(6))];
      end else if (pick < 85) begin
         a.op = OP_CHECK_COND;
      end else if (pick < 93) begin
         a.op = OP_READ_SAVED;
      end else begin
         a.op = OP_WRITE_SAVED;
      end
      return a;
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes, every opcode, illegal and repeated modes, saved status
   // in user mode, T-bit flush both ways, and the supervisor r14 slot.
   task automatic test_directed();
      req_idle_pct = 37;
      rsp_idle_pct = 71;
      send_access(make_access(OP_READ_REG,    4'd0,  32'h0, 5'h00, COND_EQ));
      send_access(make_access(OP_UNUSED,      4'd15, 32'hFFFF_FFFF, 5'h1F, 4'd15));
      send_access(make_access(OP_WRITE_REG,   4'd15, 32'hFFFF_FFFF, 5'h00, COND_EQ));
      send_access(make_access(OP_READ_REG,    4'd15, 32'h0, 5'h00, COND_EQ));
      send_access(make_access(OP_READ_SAVED,  4'd0,  32'h0, 5'h00, COND_EQ));
      send_access(make_access(OP_WRITE_SAVED, 4'd0,  32'h0000_0001, 5'h00, COND_EQ));
      send_access(make_access(OP_SET_MODE,    4'd0,  32'h0, MODE_FIQ, COND_EQ));
      send_access(make_access(OP_WRITE_REG,   4'd8,  32'hA5A5_A5A5, 5'h00, COND_EQ));
      send_access(make_access(OP_READ_REG,    4'd8,  32'h0, 5'h00, COND_EQ));
      send_access(make_access(OP_WRITE_SAVED, 4'd0,  32'hFFFF_FFFF, 5'h00, COND_EQ));
      send_access(make_access(OP_READ_SAVED,  4'd0,  32'h0, 5'h00, COND_EQ));
      // same mode again: no re-select, no error
      send_access(make_access(OP_SET_MODE,    4'd0,  32'h0, MODE_FIQ, COND_EQ));
      // illegal mode: stored, bank stays FIQ, error; then repeated silently
      send_access(make_access(OP_SET_MODE,    4'd0,  32'h0, 5'h00, COND_EQ));
      send_access(make_access(OP_SET_MODE,    4'd0,  32'h0, 5'h00, COND_EQ));
      send_access(make_access(OP_READ_REG,    4'd8,  32'h0, 5'h00, COND_EQ));
      // all ones: system mode, T set -> flush, masked store
      send_access(make_access(OP_WRITE_STAT,  4'd0,  32'hFFFF_FFFF, 5'h00, COND_EQ));
      send_access(make_access(OP_CHECK_COND,  4'd0,  32'h0, 5'h00, COND_GT));
      send_access(make_access(OP_CHECK_COND,  4'd0,  32'h0, 5'h00, 4'd15));
      send_access(make_access(OP_SET_MODE,    4'd0,  32'h0, MODE_SVC, COND_EQ));
      send_access(make_access(OP_WRITE_REG,   4'd14, 32'h1234_5678, 5'h00, COND_EQ));
      send_access(make_access(OP_READ_REG,    4'd14, 32'h0, 5'h00, COND_EQ));
      send_access(make_access(OP_READ_SAVED,  4'd0,  32'h0, 5'h00, COND_EQ));
      // back to user with T cleared -> flush again
      send_access(make_access(OP_WRITE_STAT,  4'd0,  32'h0000_0010, 5'h00, COND_EQ));
      send_access(make_access(OP_READ_REG,    4'd14, 32'h0, 5'h00, COND_EQ));
      send_access(make_access(OP_CHECK_COND,  4'd0,  32'h0, 5'h00, COND_EQ));
   endtask

   task automatic test_random_traffic(input int count, input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (count) send_access(random_access());
   endtask

   // Receiver holds off for a long stretch while the sender keeps pushing,
   // so the pipeline fills and req_tready must drop.
   task automatic test_output_stall();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_cycles = 120;
      repeat (30) send_access(random_access());
   endtask

   // ---------------------------------------------------------------------------
   // Receiver side: random stalls, or one long counted hold-off on request.
   // ---------------------------------------------------------------------------
   initial begin : rsp_driver
      int held;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            held = 0;
            while (held < rsp_hold_cycles) begin
               @(posedge clock);
               held++;
            end
            rsp_hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response checking, in order against the predicted queue.
   // ---------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch on result %0d, expected %h actual %h",
                  $time, name, results_checked, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (access_results_q.size() == 0) begin
            error_count++;
            $display("%0t: response with nothing pending, expected none actual %h",
                     $time, rsp_tdata);
         end else begin
            want = access_results_q.pop_front();
            check_field("read_data",   want.read_data, rsp_tdata[31:0]);
            check_field("cond_passed", 32'(want.cond_passed), 32'(rsp_tdata[32]));
            check_field("flush",       32'(want.flush), 32'(rsp_tdata[33]));
            check_field("error",       32'(want.error), 32'(rsp_tdata[35:34]));
         end
         results_checked++;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : main_sequence
      int drain;
      foreach (gpr_image[i]) gpr_image[i] = '0;
      foreach (spsr_image[i]) spsr_image[i] = '0;
      foreach (op_count[i]) op_count[i] = 0;
      psr_image       = STATUS_RESET;
      bank_image      = BANK_USR;
      error_count     = 0;
      items_sent      = 0;
      results_checked = 0;
      req_idle_pct    = 0;
      rsp_idle_pct    = 0;
      rsp_hold_cycles = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(280, 37, 71);
      test_output_stall();
      test_random_traffic(280, 71, 37);
      test_random_traffic(236, 0, 0);

      req_tvalid <= 1'b0;
      // drain, bounded; short latency plus a margin afterward
      for (drain = 0; drain < 5000 && access_results_q.size() != 0; drain++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (access_results_q.size() != 0) begin
         error_count += access_results_q.size();
         $display("%0t: %0d responses never arrived, expected %0d actual 0",
                  $time, access_results_q.size(), access_results_q.size());
      end

      $display("Summary: %0d items sent, %0d responses checked, %0d mismatches",
               items_sent, results_checked, error_count);
      $display("  items per opcode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               op_count[0], op_count[1], op_count[2], op_count[3],
               op_count[4], op_count[5], op_count[6], op_count[7]);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: banked_register_file_with_status.f
sv/rbf_pkg.sv
sv/rbf_bank.sv
sv/rbf_status.sv
sv/banked_register_file_with_status.sv
dv/tb_banked_register_file_with_status.sv
